// ===== design/cwm_pkg.sv =====
// cwm_pkg: shared types and constants for the capture measurement block
// no dependencies

package cwm_pkg;

    localparam int unsigned FREQ_W = 20;
    localparam int unsigned TIME_W = 27;
    localparam int unsigned PER_W  = 17;
    localparam int unsigned THR_W  = 12;
    localparam logic [26:0] TIME_SAT = 27'h7FFFFFF;
    localparam logic [19:0] FREQ_NUM = 20'd1000000;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // store a sample pair
        logic start;     // begin measurement of the current channel
        logic scan;      // one scan step
        logic div_start; // start divisions
        logic div_step;  // one divider step
        logic clear;     // reset capture statistics
        logic next_ch;   // advance to channel two
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic timing;    // swing large enough and samples present
        logic scan_done;
        logic div_done;
        logic ch;        // channel being measured
    } t_status;

endpackage

// ===== design/cwm_datapath.sv =====
// cwm_datapath: sample stores, running statistics, edge scan and dividers
// depends on cwm_pkg

module cwm_datapath
    import cwm_pkg::*;
#(
    parameter int unsigned CAPTURE_DEPTH = 1024,
    parameter int unsigned SAMPLE_BITS   = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [SAMPLE_BITS-1:0] i_s1,
    input  logic [SAMPLE_BITS-1:0] i_s2,
    input  logic [PER_W-1:0]       i_period,
    input  logic [THR_W-1:0]       i_thresh,
    output logic                   o_channel,
    output logic [SAMPLE_BITS-1:0] o_max,
    output logic [SAMPLE_BITS-1:0] o_min,
    output logic [SAMPLE_BITS-1:0] o_swing,
    output logic [SAMPLE_BITS-1:0] o_mean,
    output logic [FREQ_W-1:0]      o_freq,
    output logic [TIME_W-1:0]      o_high,
    output logic                   o_high_v,
    output logic [TIME_W-1:0]      o_low,
    output logic                   o_low_v
);

    localparam int unsigned AW   = $clog2(CAPTURE_DEPTH);
    localparam int unsigned CW   = $clog2(CAPTURE_DEPTH + 1);
    localparam int unsigned SW   = SAMPLE_BITS + CW;
    localparam int unsigned DW   = CW + PER_W;  // denominator width
    localparam int unsigned QW   = SW;          // mean quotient width
    localparam int unsigned STEPS = (DW > SW) ? DW : SW;
    localparam int unsigned KW   = $clog2(STEPS + 1);
    localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};

    logic [SAMPLE_BITS-1:0] r_mem1 [CAPTURE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_mem2 [CAPTURE_DEPTH];
    logic [CW-1:0]          r_cnt;
    logic [SAMPLE_BITS-1:0] r_max [2];
    logic [SAMPLE_BITS-1:0] r_min [2];
    logic [SW-1:0]          r_sum [2];
    logic                   r_ch;

    // capture load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_cnt < CW'(CAPTURE_DEPTH)) begin
            r_mem1[r_cnt[AW-1:0]] <= i_s1;
            r_mem2[r_cnt[AW-1:0]] <= i_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt <= '0;
            r_ch  <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_max[c] <= '0;
                r_min[c] <= SMAX;
                r_sum[c] <= '0;
            end
        end else begin
            if (i_cmd.next_ch) r_ch <= 1'b1;
            if (i_cmd.load && r_cnt < CW'(CAPTURE_DEPTH)) begin
                r_cnt <= r_cnt + 1'b1;
                r_sum[0] <= r_sum[0] + SW'(i_s1);
                r_sum[1] <= r_sum[1] + SW'(i_s2);
                if (i_s1 > r_max[0]) r_max[0] <= i_s1;
                if (i_s2 > r_max[1]) r_max[1] <= i_s2;
                if (i_s1 < r_min[0]) r_min[0] <= i_s1;
                if (i_s2 < r_min[1]) r_min[1] <= i_s2;
            end
        end
    end

    // per channel measurement
    logic [SAMPLE_BITS-1:0] vmax, vmin, swing;
    logic [SAMPLE_BITS:0]   msum;
    logic [SAMPLE_BITS-1:0] r_mid;
    logic [PER_W-1:0]       per;
    logic                   timing;

    assign vmax  = r_max[r_ch];
    assign vmin  = r_min[r_ch];
    assign swing = (vmax >= vmin) ? vmax - vmin : '0;
    assign msum  = {1'b0, vmax} + {1'b0, vmin};
    assign per   = (i_period == '0) ? PER_W'(1) : i_period;
    // compare at a common width so any sample width works
    assign timing = (r_cnt != '0) && (vmax >= vmin) &&
                    (32'(swing) >= 32'(i_thresh));

    // scan: registered memory read, one sample per cycle
    logic [CW-1:0]          r_ri;      // read address
    logic [CW-1:0]          r_ci;      // index of sample in r_cur
    logic                   r_rdv;
    logic [SAMPLE_BITS-1:0] r_cur, r_prev;
    logic                   r_hasp;
    logic                   r_hr1, r_hf1, r_hr2, r_sdone;
    logic [CW-1:0]          r_r1, r_f1, r_r2;
    logic                   rise, fall;

    always_ff @(posedge i_clk) begin
        r_cur <= r_ch ? r_mem2[r_ri[AW-1:0]] : r_mem1[r_ri[AW-1:0]];
    end

    assign rise = r_hasp && r_prev < r_mid && r_cur >= r_mid;
    assign fall = r_hasp && r_prev > r_mid && r_cur <= r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdone <= 1'b0;
            r_rdv   <= 1'b0;
            r_hasp  <= 1'b0;
            r_hr1   <= 1'b0;
            r_hf1   <= 1'b0;
            r_hr2   <= 1'b0;
        end else if (i_cmd.start) begin
            r_mid   <= msum[SAMPLE_BITS:1];
            r_ri    <= '0;
            r_rdv   <= 1'b0;
            r_hasp  <= 1'b0;
            r_hr1   <= 1'b0;
            r_hf1   <= 1'b0;
            r_hr2   <= 1'b0;
            r_sdone <= 1'b0;
        end else if (i_cmd.scan && !r_sdone) begin
            r_rdv <= (r_ri < r_cnt);
            r_ci  <= r_ri;
            if (r_ri < r_cnt) r_ri <= r_ri + 1'b1;
            if (r_rdv) begin
                r_prev <= r_cur;
                r_hasp <= 1'b1;
                if (rise) begin
                    if (!r_hr1) begin
                        r_hr1 <= 1'b1;
                        r_r1  <= r_ci;
                    end else if (r_hf1) begin
                        r_hr2   <= 1'b1;
                        r_r2    <= r_ci;
                        r_sdone <= 1'b1;
                    end
                end else if (fall && r_hr1 && !r_hf1) begin
                    r_hf1 <= 1'b1;
                    r_f1  <= r_ci;
                end
            end else if (r_ri >= r_cnt) begin
                r_sdone <= 1'b1;
            end
        end
    end

    // shared restoring dividers for mean and frequency, one bit per step
    logic [QW-1:0] r_mq;
    logic [SW-1:0] r_mr;
    logic [CW-1:0] r_md;
    logic [FREQ_W-1:0] r_fq;
    logic [DW:0]       r_fr;
    logic [DW-1:0]     r_fd;
    logic [KW-1:0]     r_k;
    logic              r_ddone;
    logic [SW:0]       mtr;
    logic [DW:0]       ftr;
    logic [DW-1:0]     den;

    assign den = DW'(r_r2 - r_r1) * DW'(per);
    assign mtr = {r_mr, r_mq[QW-1]};
    assign ftr = {r_fr[DW-1:0], r_fq[FREQ_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ddone <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_mq <= r_sum[r_ch];
            r_mr <= '0;
            r_md <= (r_cnt == '0) ? CW'(1) : r_cnt;
            r_fq <= FREQ_NUM;
            r_fr <= '0;
            r_fd <= (r_hr2 && timing) ? den : DW'(FREQ_NUM) + 1'b1;
            r_k  <= '0;
            r_ddone <= 1'b0;
        end else if (i_cmd.div_step && !r_ddone) begin
            r_k <= r_k + 1'b1;
            if (r_k < KW'(SW)) begin
                if (mtr >= (SW+1)'(r_md)) begin
                    r_mr <= SW'(mtr - (SW+1)'(r_md));
                    r_mq <= {r_mq[QW-2:0], 1'b1};
                end else begin
                    r_mr <= mtr[SW-1:0];
                    r_mq <= {r_mq[QW-2:0], 1'b0};
                end
            end
            if (r_k < KW'(FREQ_W)) begin
                if (ftr >= {1'b0, r_fd}) begin
                    r_fr <= ftr - {1'b0, r_fd};
                    r_fq <= {r_fq[FREQ_W-2:0], 1'b1};
                end else begin
                    r_fr <= ftr;
                    r_fq <= {r_fq[FREQ_W-2:0], 1'b0};
                end
            end
            if (r_k == KW'(STEPS - 1)) r_ddone <= 1'b1;
        end
    end

    // time products (saturated)
    logic [DW-1:0] hprod, lprod;
    assign hprod = DW'(r_f1 - r_r1) * DW'(per);
    assign lprod = DW'(r_r2 - r_f1) * DW'(per);

    assign o_channel = r_ch;
    assign o_max     = vmax;
    assign o_min     = vmin;
    assign o_swing   = swing;
    assign o_mean    = r_mq[SAMPLE_BITS-1:0];
    assign o_freq    = (timing && r_hr2) ? r_fq : '0;
    assign o_high_v  = timing && r_hf1;
    assign o_low_v   = timing && r_hr2;
    assign o_high    = !o_high_v ? '0 :
                       (hprod > DW'(TIME_SAT)) ? TIME_SAT : TIME_W'(hprod);
    assign o_low     = !o_low_v ? '0 :
                       (lprod > DW'(TIME_SAT)) ? TIME_SAT : TIME_W'(lprod);

    assign o_status.timing    = timing;
    assign o_status.scan_done = r_sdone;
    assign o_status.div_done  = r_ddone;
    assign o_status.ch        = r_ch;

    // edges are found in order
    a_f1_after_r1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hf1 |-> r_hr1) else $error("falling edge without rising edge");
    a_r2_after_f1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hr2 |-> r_hf1) else $error("second rising edge without falling edge");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPTURE_DEPTH)) else $error("sample count beyond depth");

endmodule

// ===== design/cwm_ctrl.sv =====
// cwm_ctrl: sequencer for load, scan, divide and result delivery
// depends on cwm_pkg

module cwm_ctrl
    import cwm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output logic    o_last,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DIVS  = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign acc = i_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = (r_state == S_OUT);
    assign o_last      = i_status.ch;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = acc;
                if (acc && i_last) n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.start = 1'b1;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (i_status.ch) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.next_ch = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else          r_state <= n_state;
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_LOAD) else $error("load while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid) else $error("result dropped");

endmodule

// ===== design/capture_waveform_measurement.sv =====
// capture_waveform_measurement: two-channel capture with automatic measurements
// depends on cwm_pkg, cwm_ctrl, cwm_datapath
//
// channel   direction  handshake                payload
// input     in         i_valid / o_stall        ch1, ch2 samples, end flag
// result    out        o_valid / i_stall        channel stats and timing
// config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// loading accepts one sample pair per cycle
// after the last pair each channel is scanned over the
// stored samples (one memory read a cycle), then 28 divider steps
// reset clears statistics, state and control flags and sets the configuration defaults; stores need no clearing
// the input stalls from the last pair until both results are taken

module capture_waveform_measurement
    import cwm_pkg::*;
#(
    parameter int unsigned CAPTURE_DEPTH = 1024,
    parameter int unsigned SAMPLE_BITS   = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_ch1_sample,
    input  logic [SAMPLE_BITS-1:0] i_ch2_sample,
    input  logic                   i_end_of_capture,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_channel,
    output logic [SAMPLE_BITS-1:0] o_max_code,
    output logic [SAMPLE_BITS-1:0] o_min_code,
    output logic [SAMPLE_BITS-1:0] o_swing_code,
    output logic [SAMPLE_BITS-1:0] o_mean_code,
    output logic [FREQ_W-1:0]      o_freq_hz,
    output logic [TIME_W-1:0]      o_high_time_us,
    output logic                   o_high_valid,
    output logic [TIME_W-1:0]      o_low_time_us,
    output logic                   o_low_valid,
    output logic                   o_last_result,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [PER_W-1:0]       i_cfg_data
);

    logic [PER_W-1:0] r_period;
    logic [THR_W-1:0] r_thresh;
    t_cmd             cmd;
    t_status          status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PER_W'(1);
            r_thresh <= THR_W'(30);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PERIOD: r_period <= i_cfg_data;
                REG_THRESH: r_thresh <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    cwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last      (i_end_of_capture),
        .o_in_stall  (o_stall),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_last      (o_last_result),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cwm_datapath #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_s1     (i_ch1_sample),
        .i_s2     (i_ch2_sample),
        .i_period (r_period),
        .i_thresh (r_thresh),
        .o_channel(o_channel),
        .o_max    (o_max_code),
        .o_min    (o_min_code),
        .o_swing  (o_swing_code),
        .o_mean   (o_mean_code),
        .o_freq   (o_freq_hz),
        .o_high   (o_high_time_us),
        .o_high_v (o_high_valid),
        .o_low    (o_low_time_us),
        .o_low_v  (o_low_valid)
    );

endmodule
